// ===== rtl/cch_pkg.sv =====
// ----------------------------------------------------------------------------
// cch_pkg: shared types and constants of the counting chained hash table
// Item layouts for both channels, command and status codes, hash constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cch_pkg;

    localparam int BUCKETS_DEF = 4096;
    localparam int ENTRIES_DEF = 4096;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    // key+1 needs 33 bits signed; |key+1|*3+82 stays below 2^33
    localparam int MAG_W   = 33;
    localparam int HASH_W  = 34;

    localparam logic [HASH_W-1:0] HASH_OFFSET = HASH_W'(82);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
    } t_cmd_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
    } t_res_item;

endpackage

`default_nettype wire

// ===== rtl/counting_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// counting_chained_hash_table: hash multiset of signed 32-bit keys
// Insert and count queries over a separately chained table held in RAM.
// ----------------------------------------------------------------------------
// The block takes one item at a time: an insert bumps the key's count
// (saturating at all ones) or links a new entry with count 1 at the head of
// its bucket's chain; a query returns the stored count, or 0 when absent.
// When every entry is taken, an insert of a new key is dropped and reported
// with status FULL. The bucket is (|key+1|*3+82) mod BUCKETS, reduced on one
// shared multiplier: the low and high hash halves are multiplied by the
// reciprocal of BUCKETS to estimate the quotient, the quotient is multiplied
// back by BUCKETS, and one compare-and-subtract fixes the remainder. After
// acceptance the key is scaled, reduced and its bucket head read; then each
// visited entry costs one entry RAM read and one compare, and a miss goes
// through a link-or-report step before the result is loaded. The input is
// ready again in the cycle after the result is loaded; a result still
// waiting in the output register holds the block in its last step until
// that result is taken. After reset the bucket head RAM is cleared one
// bucket per cycle, and the input stays not ready until every bucket is
// cleared. A finished result waits in the output register while the next
// item is already accepted.
`default_nettype none

module counting_chained_hash_table #(
    parameter int BUCKETS = cch_pkg::BUCKETS_DEF,
    parameter int ENTRIES = cch_pkg::ENTRIES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  cch_pkg::t_cmd_item  i_in_item,

    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cch_pkg::t_res_item  o_out_item
);

    import cch_pkg::*;

    // bucket address, entry address, entry number (0 = none, 1..ENTRIES)
    localparam int BA = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EA = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW = $clog2(ENTRIES + 1);

    // shared multiplier: hash split in two halves, quotient times BUCKETS
    localparam int SPLIT = 17;
    localparam int MA    = (BA + 1 > SPLIT) ? BA + 1 : SPLIT;
    localparam int PW    = MA + MAG_W;
    localparam int ACC_W = 2 * MAG_W;

    localparam logic [BA:0]   BUCKETS_C   = (BA + 1)'(BUCKETS);
    localparam logic [BA-1:0] LAST_BUCKET = BA'(BUCKETS - 1);
    localparam logic [EW-1:0] ENTRIES_C   = EW'(ENTRIES);
    // floor(2^33 / BUCKETS); the hash stays below 2^33
    localparam logic [MAG_W-1:0] RECIP =
        MAG_W'((64'd1 << (HASH_W - 1)) / 64'(BUCKETS));

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;  // zero the bucket heads
    localparam logic [3:0] S_IDLE  = 4'd1;  // wait for an item
    localparam logic [3:0] S_SCALE = 4'd2;  // |key+1|*3+82
    localparam logic [3:0] S_MUL0  = 4'd3;  // low hash half times reciprocal
    localparam logic [3:0] S_HREAD = 4'd4;  // read bucket head
    localparam logic [3:0] S_HLOAD = 4'd5;  // latch head as walk pointer
    localparam logic [3:0] S_WALK  = 4'd6;  // check link, read entry
    localparam logic [3:0] S_CMP   = 4'd7;  // compare entry key
    localparam logic [3:0] S_MISS  = 4'd8;  // key absent: link or report
    localparam logic [3:0] S_EMIT  = 4'd9;  // hand result to output register
    localparam logic [3:0] S_MUL1  = 4'd10; // high hash half times reciprocal
    localparam logic [3:0] S_QMUL  = 4'd11; // quotient times BUCKETS
    localparam logic [3:0] S_FIX   = 4'd12; // final compare and subtract

    logic [3:0]        r_state;
    logic [3:0]        n_state;

    // item being worked on
    logic              r_command;
    logic [KEY_W-1:0]  r_key;
    logic [HASH_W-1:0] r_val;
    logic [ACC_W-1:0]  r_acc;
    logic [BA:0]       r_fold;
    logic [BA-1:0]     r_rem;
    logic [BA-1:0]     r_clr;
    logic [EW-1:0]     r_head;
    logic [EW-1:0]     r_ptr;
    logic [EW-1:0]     r_steps;
    logic [EW-1:0]     r_used;
    t_res_item         r_res;

    logic              r_out_valid;
    t_res_item         r_out;

    // memories
    logic [EW-1:0]      r_head_mem [BUCKETS];
    logic [KEY_W-1:0]   r_key_mem  [ENTRIES];
    logic [EW-1:0]      r_next_mem [ENTRIES];
    logic [COUNT_W-1:0] r_cnt_mem  [ENTRIES];

    logic [EW-1:0]      r_head_q;
    logic [KEY_W-1:0]   r_key_q;
    logic [EW-1:0]      r_next_q;
    logic [COUNT_W-1:0] r_cnt_q;

    logic               w_accept;
    logic [MAG_W-1:0]   w_inc;
    logic [MAG_W-1:0]   w_mag;
    logic [MA-1:0]      w_mul_a;
    logic [MAG_W-1:0]   w_mul_b;
    logic [PW-1:0]      w_prod;
    logic [BA:0]        w_fold_sub;
    logic               w_link_end;
    logic               w_match;
    logic               w_full;
    logic [COUNT_W-1:0] w_cnt_inc;
    logic [EW-1:0]      w_ptr_dec;
    logic [EA-1:0]      w_ent_raddr;
    logic [EA-1:0]      w_ent_waddr;
    logic               w_head_we;
    logic [BA-1:0]      w_head_waddr;
    logic [EW-1:0]      w_head_wdata;
    logic               w_new_we;
    logic               w_cnt_we;
    logic [COUNT_W-1:0] w_cnt_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // |key+1| in 33 bits: sign extend, add one, negate if negative
    assign w_inc = {i_in_item.key[KEY_W-1], i_in_item.key} + MAG_W'(1);
    assign w_mag = w_inc[MAG_W-1] ? (~w_inc + MAG_W'(1)) : w_inc;

    // shared multiplier: hash halves times the reciprocal, then the
    // quotient estimate (hash * RECIP) >> 33 times BUCKETS
    assign w_mul_a = (r_state == S_MUL0) ? MA'(r_val[SPLIT-1:0]) :
                     (r_state == S_MUL1) ? MA'(r_val[HASH_W-1:SPLIT]) :
                                           MA'(r_acc[HASH_W-1+BA:HASH_W-1]);
    assign w_mul_b = (r_state == S_QMUL) ? MAG_W'(BUCKETS_C) : RECIP;
    assign w_prod  = PW'(w_mul_a) * PW'(w_mul_b);

    // the estimate is short by at most one, so subtract BUCKETS once
    assign w_fold_sub = r_fold - BUCKETS_C;

    // chain walk
    assign w_link_end  = (r_ptr == '0) || (r_ptr > r_used) || (r_steps == ENTRIES_C);
    assign w_ptr_dec   = r_ptr - EW'(1);
    assign w_ent_raddr = w_ptr_dec[EA-1:0];
    assign w_match     = (r_key_q == r_key);
    assign w_cnt_inc   = (r_cnt_q == '1) ? r_cnt_q : (r_cnt_q + COUNT_W'(1));
    assign w_full      = (r_used >= ENTRIES_C);

    // memory write controls
    assign w_new_we     = (r_state == S_MISS) && (r_command == CMD_INSERT) && !w_full;
    assign w_head_we    = (r_state == S_CLEAR) || w_new_we;
    assign w_head_waddr = (r_state == S_CLEAR) ? r_clr : r_rem;
    assign w_head_wdata = (r_state == S_CLEAR) ? '0 : (r_used + EW'(1));
    assign w_cnt_we     = w_new_we ||
                          ((r_state == S_CMP) && w_match && (r_command == CMD_INSERT));
    assign w_cnt_wdata  = w_new_we ? COUNT_W'(1) : w_cnt_inc;
    assign w_ent_waddr  = w_new_we ? r_used[EA-1:0] : w_ent_raddr;

    // bucket head RAM: one write port, one registered read at the bucket
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[w_head_waddr] <= w_head_wdata;
        end
        r_head_q <= r_head_mem[r_rem];
    end

    // entry RAMs: key, link and count read together at the walk pointer
    always_ff @(posedge i_clk) begin
        if (w_new_we) begin
            r_key_mem[w_ent_waddr]  <= r_key;
            r_next_mem[w_ent_waddr] <= r_head;
        end
        if (w_cnt_we) begin
            r_cnt_mem[w_ent_waddr] <= w_cnt_wdata;
        end
        r_key_q  <= r_key_mem[w_ent_raddr];
        r_next_q <= r_next_mem[w_ent_raddr];
        r_cnt_q  <= r_cnt_mem[w_ent_raddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST_BUCKET) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_SCALE;
            S_SCALE: n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_QMUL;
            S_QMUL:  n_state = S_FIX;
            S_FIX:   n_state = S_HREAD;
            S_HREAD: n_state = S_HLOAD;
            S_HLOAD: n_state = S_WALK;
            S_WALK:  n_state = w_link_end ? S_MISS : S_CMP;
            S_CMP:   n_state = w_match ? S_EMIT : S_WALK;
            S_MISS:  n_state = S_EMIT;
            S_EMIT:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + BA'(1);
            end
            if (w_new_we) begin
                r_used <= r_used + EW'(1);
            end
            // drop the valid once taken, raise it when a result is handed over
            if (r_state == S_EMIT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_command <= i_in_item.command;
                    r_key     <= i_in_item.key;
                    r_val     <= {1'b0, w_mag};
                end
            end
            S_SCALE: begin
                r_val <= r_val + {r_val[HASH_W-2:0], 1'b0} + HASH_OFFSET;
            end
            S_MUL0: begin
                r_acc <= ACC_W'(w_prod);
            end
            S_MUL1: begin
                r_acc <= r_acc + (ACC_W'(w_prod) << SPLIT);
            end
            S_QMUL: begin
                // low bits suffice: the true remainder is below 2*BUCKETS
                r_fold <= r_val[BA:0] - w_prod[BA:0];
            end
            S_FIX: begin
                r_rem <= (r_fold >= BUCKETS_C) ? w_fold_sub[BA-1:0] : r_fold[BA-1:0];
            end
            S_HLOAD: begin
                r_head  <= r_head_q;
                r_ptr   <= r_head_q;
                r_steps <= '0;
            end
            S_CMP: begin
                if (w_match) begin
                    r_res.status <= ST_OK;
                    r_res.count  <= (r_command == CMD_QUERY) ? r_cnt_q : w_cnt_inc;
                end else begin
                    // advance to the next entry of the chain
                    r_ptr   <= r_next_q;
                    r_steps <= r_steps + EW'(1);
                end
            end
            S_MISS: begin
                if (r_command == CMD_QUERY) begin
                    r_res.status <= ST_OK;
                    r_res.count  <= '0;
                end else if (w_full) begin
                    r_res.status <= ST_FULL;
                    r_res.count  <= '0;
                end else begin
                    r_res.status <= ST_OK;
                    r_res.count  <= COUNT_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_counting_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_counting_chained_hash_table: self-checking bench of the hash multiset
// Drives insert and count-query items through the valid/ready input channel,
// predicts every result with a behavioral copy of the chained table, and
// compares each result item field by field, in order, as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_counting_chained_hash_table;

    import cch_pkg::*;

    localparam int BUCKETS = BUCKETS_DEF;
    localparam int ENTRIES = ENTRIES_DEF;

    // Collision classes: keys with |key+1| equal mod BUCKETS share a bucket
    localparam int HOT_MAGS = 4;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       out_ready = 1'b0;
    t_cmd_item  in_item = '0;
    logic       in_ready;
    logic       out_valid;
    t_res_item  out_item;

    counting_chained_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    // Generous fixed cap on the whole run
    initial begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the chained table
    // ------------------------------------------------------------------------
    int unsigned        head_of [BUCKETS];
    logic [KEY_W-1:0]   slot_key [ENTRIES];
    int unsigned        slot_next [ENTRIES];
    logic [COUNT_W-1:0] slot_count [ENTRIES];
    int unsigned        slots_used = 0;

    t_res_item          expected_results [$];
    logic signed [KEY_W-1:0] key_pool [$];

    int  errors = 0;
    bit  tx_idle = 1'b1;    // sender inserts gaps
    bit  rx_idle = 1'b1;    // receiver inserts stalls
    int  hold_left = 0;     // long receiver hold-off, counted down below
    int  stall_left = 0;
    int  hot_mag [HOT_MAGS] = '{5, 1000, 2047, 4095};

    // (|key+1| * 3 + 82) mod BUCKETS, at the block's widths
    function automatic int unsigned hash_bucket(logic signed [KEY_W-1:0] key);
        logic signed [MAG_W-1:0] key_p1;
        logic [MAG_W-1:0]        mag;
        logic [HASH_W-1:0]       hv;
        key_p1 = {key[KEY_W-1], key} + 33'sd1;
        mag    = key_p1[MAG_W-1] ? (33'd0 - key_p1) : key_p1;
        hv     = HASH_W'(mag) * 34'd3 + HASH_OFFSET;
        return int'(hv % HASH_W'(BUCKETS));
    endfunction

    // Walk the chain newest first; 0 means absent
    function automatic int unsigned find_entry(logic signed [KEY_W-1:0] key);
        int unsigned e;
        e = head_of[hash_bucket(key)];
        for (int steps = 0; steps < ENTRIES; steps++) begin
            if (e == 0 || e > slots_used) return 0;
            if (slot_key[e-1] == key) return e;
            e = slot_next[e-1];
        end
        return 0;
    endfunction

    function automatic t_res_item predict_result(logic cmd, logic signed [KEY_W-1:0] key);
        t_res_item   r;
        int unsigned e;
        int unsigned b;
        b = hash_bucket(key);
        e = find_entry(key);
        r.count  = '0;
        r.status = ST_OK;
        if (cmd == CMD_QUERY) begin
            if (e != 0) r.count = slot_count[e-1];
        end else if (e != 0) begin
            if (slot_count[e-1] != '1) slot_count[e-1] = slot_count[e-1] + 1'b1;
            r.count = slot_count[e-1];
        end else if (slots_used >= ENTRIES) begin
            r.status = ST_FULL;
        end else begin
            slot_next[slots_used]  = head_of[b];
            slot_key[slots_used]   = key;
            slot_count[slots_used] = 1;
            slots_used             = slots_used + 1;
            head_of[b]             = slots_used;
            r.count                = 1;
        end
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one item, hold it until accepted, then maybe idle
    // ------------------------------------------------------------------------
    task automatic send_item(logic cmd, logic signed [KEY_W-1:0] key);
        int gap;
        in_valid      <= 1'b1;
        in_item.command <= cmd;
        in_item.key   <= key;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        expected_results.push_back(predict_result(cmd, key));
        if (cmd == CMD_INSERT) begin
            if (key_pool.size() < 512) key_pool.push_back(key);
            else key_pool[$urandom_range(0, 511)] = key;
        end
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_for_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < 500_000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("results stopped coming, %0d outstanding", expected_results.size());
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, optional long hold-off, in-order check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: count %0d status %0d",
                           out_item.count, out_item.status);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.count !== want.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, out_item.count);
                        errors++;
                    end
                    if (out_item.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_item.status);
                        errors++;
                    end
                end
            end
            // Hold off first, then random stalls, else accept
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                if (rx_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extreme keys, both commands, repeats and bucket collisions
    task automatic test_directed();
        send_item(CMD_QUERY,  32'sd0);              // absent in empty table
        send_item(CMD_INSERT, 32'sd0);
        send_item(CMD_INSERT, 32'sd0);              // repeat counts up
        send_item(CMD_QUERY,  32'sd0);
        send_item(CMD_QUERY,  -32'sd2);             // same bucket as 0, absent
        send_item(CMD_INSERT, -32'sd2);             // collides with 0
        send_item(CMD_QUERY,  32'sd0);              // walk past the newer entry
        send_item(CMD_INSERT, -32'sd1);             // key+1 is zero
        send_item(CMD_INSERT, 32'sh7FFF_FFFF);      // key+1 needs the 33rd bit
        send_item(CMD_QUERY,  -32'sd1);
        send_item(CMD_INSERT, 32'sh8000_0000);      // most negative key
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_QUERY,  32'sh8000_0000);
        send_item(CMD_QUERY,  32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 32'sh5555_5555);
        send_item(CMD_INSERT, 32'shAAAA_AAAA);
        send_item(CMD_QUERY,  32'sh5555_5555);
        send_item(CMD_QUERY,  32'shAAAA_AAAA);
        send_item(CMD_QUERY,  32'sh7FFF_FFFE);      // absent
        send_item(CMD_INSERT, 32'sh7FFF_FFFF);
        wait_for_results();
    endtask

    // Random mix: pool repeats, collision keys, extremes and wild keys
    task automatic test_random_mix(int n_items);
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic [MAG_W-1:0]        mag;
        int                      pick;
        for (int i = 0; i < n_items; i++) begin
            // Alternate stretches with and without idling
            tx_idle = ((i / 200) % 3) != 2;
            rx_idle = ((i / 150) % 4) != 1;
            cmd  = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 40 && key_pool.size() != 0) begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else if (pick < 60) begin
                mag = MAG_W'(hot_mag[$urandom_range(0, HOT_MAGS - 1)])
                      + MAG_W'(BUCKETS) * MAG_W'($urandom_range(0, 15));
                key = $urandom_range(0, 1) ? KEY_W'(mag - 1'b1) : KEY_W'(-mag - 1'b1);
            end else if (pick < 70) begin
                case ($urandom_range(0, 5))
                    0: key = 32'sd0;
                    1: key = -32'sd1;
                    2: key = 32'sh7FFF_FFFF;
                    3: key = 32'sh8000_0000;
                    4: key = 32'sd1;
                    default: key = -32'sd2;
                endcase
            end else begin
                key = $urandom();
            end
            send_item(cmd, key);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_for_results();
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure();
        tx_idle   = 1'b0;
        hold_left = 400;
        for (int i = 0; i < 12; i++) begin
            send_item(i[0] ? CMD_QUERY : CMD_INSERT,
                      key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end
        tx_idle = 1'b1;
        wait_for_results();
    endtask

    // Take every free entry with fresh keys, spread over the buckets
    task automatic test_fill_store();
        logic signed [KEY_W-1:0] key;
        int                      i;
        i = 0;
        while (slots_used < ENTRIES) begin
            key = 32'sh4000_0000 + i;
            i++;
            tx_idle = (i % 512) < 128;
            rx_idle = (i % 512) < 128;
            if (find_entry(key) != 0) continue;
            send_item(CMD_INSERT, key);
            if (i % 16 == 0)
                send_item(CMD_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_for_results();
    endtask

    // With the store full: new keys drop, known keys still count
    task automatic test_store_full();
        logic signed [KEY_W-1:0] key;
        for (int j = 0; j < 8; j++) begin
            key = 32'sh7000_0000 + j * 7;
            if (find_entry(key) == 0) begin
                send_item(CMD_INSERT, key);
                send_item(CMD_QUERY, key);
            end
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item(CMD_INSERT, key);
            send_item(CMD_QUERY, key);
        end
        key = $urandom();
        send_item(CMD_INSERT, key);
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_INSERT, 32'sh7FFF_FFFE);
        send_item(CMD_QUERY,  32'sh7FFF_FFFE);
        wait_for_results();
    endtask

    initial begin
        int tail;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(1800);
        test_backpressure();
        test_fill_store();
        test_store_full();

        // Let any stray result show up before the verdict
        tail = 0;
        while (tail < 200) begin
            @(posedge i_clk);
            tail++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
